// ----- src/pva_pkg.sv -----
// -----------------------------------------------------------------------------
// pva_pkg
// Shared constants, command and outcome codes, and memory word types.
// -----------------------------------------------------------------------------
`default_nettype none
package pva_pkg;
   localparam int VOICES   = 16;
   localparam int CHANNELS = 16;
   localparam int VW = $clog2(VOICES);
   localparam int CW = 4;

   localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
   localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
   localparam logic [2:0] CMD_SUS_ON   = 3'd2;
   localparam logic [2:0] CMD_SUS_OFF  = 3'd3;
   localparam logic [2:0] CMD_TICK     = 3'd4;

   localparam logic [2:0] OC_NONE    = 3'd0;
   localparam logic [2:0] OC_ASSIGN  = 3'd1;
   localparam logic [2:0] OC_RETRIG  = 3'd2;
   localparam logic [2:0] OC_STOLEN  = 3'd3;
   localparam logic [2:0] OC_RELEASE = 3'd4;
   localparam logic [2:0] OC_HELD    = 3'd5;

   // one voice table word
   typedef struct packed {
      logic       busy;
      logic       held;
      logic [3:0] owner;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [7:0] countdown;
   } voice_word_type;
endpackage
`default_nettype wire

// ----- src/pva_ram.sv -----
// -----------------------------------------------------------------------------
// pva_ram
// Generic single-port synchronous RAM with a registered read.
// -----------------------------------------------------------------------------
`default_nettype none
module pva_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ----- src/poly_voice_allocator_top.sv -----
// -----------------------------------------------------------------------------
// poly_voice_allocator_top
// Polyphonic voice allocator: voice table and free ring held in RAM.
// -----------------------------------------------------------------------------
// Usage:
//  - Drive req_* and raise start while busy is low; the word is taken at
//    that edge. Commands are handled one at a time.
//  - Each result word sits on rsp_voice/rsp_outcome/rsp_last for one cycle
//    with rsp_valid high; rsp_last marks the final word of a command. The
//    receiver cannot stall, so every word is taken at the edge ending it.
//  - After reset a clearing pass over all VOICES (16) entries loads the voice
//    table and the free ring with their reset values; busy stays high meanwhile.
//  - Note on / note off: a scan of the voice table through the single RAM
//    port, then a decide state and a write-back state; the word is taken at
//    the same edge at which a new command can be taken.
//  - Sustain off: a read state then a write-back state per voice; each freed
//    voice is reported when the next is found, the last in the final word.
//  - Tick with n free voices (n >= 2): each ring step passes S_TK_RING,
//    S_TK_VOICE and S_TK_UPD, then S_TK_LAST makes the last ring write.
//  - Sustain on, tick on a nearly full table, unknown codes: word from S_DONE.
//  - busy is low exactly while idle; it drops at the edge that raises the
//    final word's strobe.
//  - State: voice table RAM (busy, held, owner, note, velocity, countdown),
//    free-ring RAM, head/tail/count and per-channel sustain flops.
// -----------------------------------------------------------------------------
`default_nettype none
module poly_voice_allocator_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_cmd,
   input  wire logic [3:0] req_channel,
   input  wire logic [6:0] req_note,
   input  wire logic [6:0] req_velocity,
   input  wire logic [7:0] req_release_count,
   output logic            rsp_valid,
   output logic [3:0]      rsp_voice,
   output logic [2:0]      rsp_outcome,
   output logic            rsp_last
);
   localparam int VW = pva_pkg::VW;
   localparam int VWW = $bits(pva_pkg::voice_word_type);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_SUS_RD, S_SUS_CHK,
      S_TK_RING, S_TK_VOICE, S_TK_UPD, S_TK_LAST, S_DONE
   } state_type;

   state_type state_ff;

   // voice RAM port
   logic                     vwe;
   logic [VW-1:0]            vaddr;
   pva_pkg::voice_word_type  vwdata, vrdata;
   logic [VWW-1:0]           vrraw;
   // ring RAM port
   logic                     rwe;
   logic [VW-1:0]            raddr;
   logic [VW-1:0]            rwdata, rrdata;

   pva_ram #(.DEPTH(pva_pkg::VOICES), .WIDTH(VWW)) u_voice_ram (
      .clock(clock), .we(vwe), .addr(vaddr), .wdata(vwdata), .rdata(vrraw));
   assign vrdata = pva_pkg::voice_word_type'(vrraw);

   pva_ram #(.DEPTH(pva_pkg::VOICES), .WIDTH(VW)) u_ring_ram (
      .clock(clock), .we(rwe), .addr(raddr), .wdata(rwdata), .rdata(rrdata));

   // command latch
   logic [2:0] cmd_ff;
   logic [3:0] ch_ff;
   logic [6:0] note_ff, vel_ff;
   logic [7:0] rel_ff;

   logic [VW-1:0] head_ff, tail_ff;
   logic [VW:0]   count_ff;
   logic [pva_pkg::CHANNELS-1:0] sustain_ff;

   // scan control
   logic [VW:0]   idx_ff;      // address issued (reaches VOICES at the end)
   logic          rd_ok_ff;    // a scan read was issued last cycle
   logic [VW-1:0] rd_addr_ff;
   logic          found_ff;
   logic [VW-1:0] fidx_ff;
   pva_pkg::voice_word_type fword_ff;
   logic [2:0]    outcome_ff;
   // sustain off: one freed voice waits so its last flag is known
   logic          pend_ff;
   logic [VW-1:0] pend_voice_ff;
   // tick walk
   logic [VW-1:0] p_ff, pre_ff;
   logic [VW-1:0] a_ff, pre_val_ff;  // pre_val: ring value carried for slot p
   logic [7:0]    mn_ff;
   logic          first_ff;

   // response next values
   logic          rsp_valid_in, rsp_last_in;
   logic [3:0]    rsp_voice_in;
   logic [2:0]    rsp_outcome_in;

   logic [3:0] ch_m;
   assign ch_m = 4'({28'd0, req_channel} % pva_pkg::CHANNELS);

   logic match, sus_hit, to_ring, step_keep;
   logic [7:0] k_now;
   assign match   = vrdata.busy && vrdata.owner == ch_ff && vrdata.note == note_ff;
   assign sus_hit = vrdata.busy && vrdata.owner == ch_ff && vrdata.held;
   assign to_ring = (cmd_ff == pva_pkg::CMD_NOTE_OFF) && found_ff && !sustain_ff[ch_ff];
   assign k_now   = (vrdata.countdown != 8'd0) ? vrdata.countdown - 8'd1 : 8'd0;
   assign step_keep = k_now < mn_ff;

   // RAM port control
   always_comb begin
      vwe = 1'b0; vaddr = idx_ff[VW-1:0]; vwdata = vrdata;
      rwe = 1'b0; raddr = head_ff; rwdata = pre_val_ff;
      unique case (state_ff)
         S_CLEAR: begin
            vwe = 1'b1;
            vwdata = '{busy:1'b0, held:1'b0, owner:4'd0, note:7'd0,
                       velocity:7'd32, countdown:8'd0};
            rwe = 1'b1;
            raddr = idx_ff[VW-1:0];
            rwdata = idx_ff[VW-1:0];
         end
         S_WRITE: begin
            vaddr = fidx_ff;
            vwe = found_ff;
            vwdata = fword_ff;
            raddr = tail_ff;
            rwdata = fidx_ff;
            rwe = to_ring;
         end
         S_SUS_CHK: begin
            vaddr = rd_addr_ff;
            vwdata.busy = 1'b0;
            vwdata.held = 1'b0;
            vwe = sus_hit;
            raddr = tail_ff;
            rwdata = rd_addr_ff;
            rwe = sus_hit;
         end
         S_TK_RING: raddr = p_ff;
         S_TK_VOICE: vaddr = rrdata;
         S_TK_UPD: begin
            // slot pre is final now: keep its carried value or take a (swap)
            vaddr = a_ff;
            vwdata.countdown = k_now;
            vwe = !first_ff;
            raddr = pre_ff;
            rwdata = step_keep ? pre_val_ff : a_ff;
            rwe = !first_ff;
         end
         S_TK_LAST: begin
            raddr = p_ff;
            rwdata = pre_val_ff;
            rwe = 1'b1;
         end
         default: ;
      endcase
   end

   // result word for the next cycle
   always_comb begin
      rsp_valid_in = 1'b0; rsp_last_in = 1'b0;
      rsp_voice_in = '0; rsp_outcome_in = pva_pkg::OC_NONE;
      unique case (state_ff)
         S_WRITE: begin
            rsp_valid_in = 1'b1; rsp_last_in = 1'b1;
            rsp_voice_in = fidx_ff; rsp_outcome_in = outcome_ff;
         end
         S_SUS_CHK: begin
            if (sus_hit && pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_voice_in = pend_voice_ff; rsp_outcome_in = pva_pkg::OC_RELEASE;
            end
         end
         S_SUS_RD: begin
            if (idx_ff[VW]) begin
               rsp_valid_in = 1'b1; rsp_last_in = 1'b1;
               if (pend_ff) begin
                  rsp_voice_in = pend_voice_ff; rsp_outcome_in = pva_pkg::OC_RELEASE;
               end
            end
         end
         S_TK_LAST, S_DONE: begin
            rsp_valid_in = 1'b1; rsp_last_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         head_ff <= '0; tail_ff <= '0; count_ff <= '0;
         sustain_ff <= '0;
         busy <= 1'b1;
         rsp_valid <= 1'b0; rsp_last <= 1'b0;
         rsp_voice <= '0; rsp_outcome <= pva_pkg::OC_NONE;
      end else begin
         rsp_valid <= rsp_valid_in; rsp_last <= rsp_last_in;
         rsp_voice <= rsp_voice_in; rsp_outcome <= rsp_outcome_in;
         unique case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == (VW+1)'(pva_pkg::VOICES - 1)) begin
                  state_ff <= S_IDLE;
                  busy <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  busy <= 1'b1;
                  cmd_ff <= req_cmd; ch_ff <= ch_m; note_ff <= req_note;
                  vel_ff <= req_velocity; rel_ff <= req_release_count;
                  idx_ff <= '0; rd_ok_ff <= 1'b0; found_ff <= 1'b0;
                  pend_ff <= 1'b0;
                  unique case (req_cmd)
                     pva_pkg::CMD_NOTE_ON, pva_pkg::CMD_NOTE_OFF: state_ff <= S_SCAN;
                     pva_pkg::CMD_SUS_ON: begin
                        sustain_ff[ch_m] <= 1'b1;
                        state_ff <= S_DONE;
                     end
                     pva_pkg::CMD_SUS_OFF: begin
                        sustain_ff[ch_m] <= 1'b0;
                        state_ff <= S_SUS_RD;
                     end
                     pva_pkg::CMD_TICK: begin
                        // no aging unless at least two voices are free
                        if (count_ff + 1'b1 >= (VW+1)'(pva_pkg::VOICES)) begin
                           state_ff <= S_DONE;
                        end else begin
                           p_ff <= tail_ff - 1'b1;
                           first_ff <= 1'b1;
                           state_ff <= S_TK_RING;
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_SCAN: begin
               // lowest matching voice wins
               if (rd_ok_ff && !found_ff && match) begin
                  found_ff <= 1'b1; fidx_ff <= rd_addr_ff; fword_ff <= vrdata;
               end
               rd_addr_ff <= idx_ff[VW-1:0];
               rd_ok_ff <= !idx_ff[VW];
               if (idx_ff[VW]) state_ff <= S_DECIDE;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_DECIDE: begin
               // rrdata holds ring[head] here
               state_ff <= S_WRITE;
               if (cmd_ff == pva_pkg::CMD_NOTE_ON) begin
                  if (found_ff) begin
                     fword_ff.countdown <= rel_ff;
                     outcome_ff <= pva_pkg::OC_RETRIG;
                  end else begin
                     found_ff <= 1'b1;
                     fword_ff <= '{busy:1'b1, held:1'b0, owner:ch_ff, note:note_ff,
                                   velocity:vel_ff, countdown:rel_ff};
                     if (count_ff >= (VW+1)'(pva_pkg::VOICES)) begin
                        // all busy: victim is the voice numbered by the head
                        fidx_ff <= head_ff;
                        outcome_ff <= pva_pkg::OC_STOLEN;
                     end else begin
                        fidx_ff <= rrdata;
                        outcome_ff <= pva_pkg::OC_ASSIGN;
                        head_ff <= head_ff + 1'b1;
                        count_ff <= count_ff + 1'b1;
                     end
                  end
               end else begin
                  if (!found_ff) begin
                     fidx_ff <= '0;
                     outcome_ff <= pva_pkg::OC_NONE;
                  end else if (sustain_ff[ch_ff]) begin
                     fword_ff.held <= 1'b1;
                     outcome_ff <= pva_pkg::OC_HELD;
                  end else begin
                     // busy and held are the two top bits of the word
                     fword_ff <= {2'b00, fword_ff[VWW-3:0]};
                     outcome_ff <= pva_pkg::OC_RELEASE;
                  end
               end
            end
            S_WRITE: begin
               if (to_ring) begin
                  tail_ff <= tail_ff + 1'b1;
                  if (count_ff != '0) count_ff <= count_ff - 1'b1;
               end
               busy <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_SUS_RD: begin
               if (idx_ff[VW]) begin
                  busy <= 1'b0;
                  state_ff <= S_IDLE;
               end else begin
                  rd_addr_ff <= idx_ff[VW-1:0];
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_SUS_CHK;
               end
            end
            S_SUS_CHK: begin
               if (sus_hit) begin
                  pend_ff <= 1'b1;
                  pend_voice_ff <= rd_addr_ff;
                  tail_ff <= tail_ff + 1'b1;
                  if (count_ff != '0) count_ff <= count_ff - 1'b1;
               end
               state_ff <= S_SUS_RD;
            end
            S_TK_RING: state_ff <= S_TK_VOICE;
            S_TK_VOICE: begin
               a_ff <= rrdata;
               state_ff <= S_TK_UPD;
            end
            S_TK_UPD: begin
               first_ff <= 1'b0;
               pre_ff <= p_ff;
               if (first_ff) begin
                  mn_ff <= vrdata.countdown;
                  pre_val_ff <= a_ff;
               end else if (step_keep) begin
                  mn_ff <= k_now;
                  pre_val_ff <= a_ff;
               end
               if (p_ff == head_ff) begin
                  state_ff <= S_TK_LAST;
               end else begin
                  p_ff <= p_ff - 1'b1;
                  state_ff <= S_TK_RING;
               end
            end
            S_TK_LAST: begin
               busy <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_DONE: begin
               busy <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_last_needs_valid;
      @(posedge clock) disable iff (reset) rsp_last |-> rsp_valid;
   endproperty
   a_last_valid: assert property (p_last_needs_valid) else $error("last without valid");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (VW+1)'(pva_pkg::VOICES)) else $error("count overflow");
   a_idle_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) == !busy) else $error("busy does not match idle");
   a_ring_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |->
      (tail_ff - head_ff) == VW'((VW+1)'(pva_pkg::VOICES) - count_ff))
      else $error("free ring fill does not match busy count");
endmodule
`default_nettype wire
